// ----- sv/packbits_rle_encoder_core_assert.svh -----
// Assertion macros for the PackBits encoder checker.
// Depends on nothing; included by pbrle_checker.sv.
`ifndef PACKBITS_RLE_ENCODER_CORE_ASSERT_SVH
`define PACKBITS_RLE_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define PBRLE_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pbrle: assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define PBRLE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pbrle: assertion failed");

`endif

// ----- sv/pbrle_pkg.sv -----
// Shared constants, codes and interface structs of the PackBits encoder.
// No dependencies; used by every module of the block.
package pbrle_pkg;

   localparam int MAX_CHUNK  = 128;
   localparam int CNT_W      = $clog2(MAX_CHUNK + 1);
   localparam int ADDR_W     = $clog2(MAX_CHUNK);
   localparam int WORD_BYTES = 4;
   localparam int BCNT_W     = $clog2(WORD_BYTES + 1);
   localparam int POS_W      = $clog2(WORD_BYTES);

   typedef logic [CNT_W-1:0] cnt_type;

   typedef enum logic [2:0] {
      BSEL_NONE,
      BSEL_RUN_HDR,
      BSEL_RUN_BYTE,
      BSEL_LIT_HDR,
      BSEL_LIT_BYTE
   } byte_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_POST_EQ,
      ST_SET_NEW,
      ST_RUN_HDR,
      ST_RUN_BYTE,
      ST_LIT_HDR,
      ST_LIT_BYTE,
      ST_EOD_CHECK,
      ST_FINAL_FLUSH,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic         load;
      logic         set_new;
      logic         set_have;
      logic         rc_inc;
      logic         push_prev;
      logic         clear_stream;
      logic         finish;
      byte_sel_type byte_sel;
   } cmd_type;

   typedef struct packed {
      logic have;
      logic match;
      logic eod;
      logic rc_gt1;
      logic rc_eq1;
      logic rc_pre_max;
      logic rc_max;
      logic lit_nz;
      logic lit_pre_full;
      logic lit_done;
   } dp_stat_type;

   typedef struct packed {
      logic byte_rdy;
      logic fin_rdy;
   } pk_stat_type;

endpackage

// ----- sv/packbits_rle_encoder_core.sv -----
// Top level of the PackBits run-length encoder: sequencer, datapath, packer.
// Depends on pbrle_pkg, pbrle_ctrl, pbrle_dp and pbrle_pack.
//
//   channel  dir  handshake            payload
//   req_     in   req_valid/req_stall  data_byte[7:0], end_of_data
//   rsp_     out  rsp_valid/rsp_stall  code_word[31:0], byte_count[2:0], last_of_item
//
// Sequence: a request that emits nothing passes through accept and decide; one that emits
// code moves one code byte per cycle while the packer can take it, plus control states.
// Reset: synchronous, active high; clears sequencer, run and literal counts and the
// result register. The literal memory needs no sweep: only entries below the count are read.
// Stalls: rsp_stall holds the result register; the byte-wide packer input sets the pace and
// the sequencer waits while the packer holds a word it cannot hand over. req_stall is low only when idle.
module packbits_rle_encoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_code_word,
   output logic [2:0]  rsp_byte_count,
   output logic        rsp_last_of_item
);

   pbrle_pkg::cmd_type     cmd;
   pbrle_pkg::dp_stat_type dp_stat;
   pbrle_pkg::pk_stat_type pk_stat;
   logic                   byte_valid;
   logic [7:0]             byte_data;

   // sequencer: accept a request, then walk run codes and literal flushes
   pbrle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_stat   (dp_stat),
      .pk_stat   (pk_stat),
      .cmd       (cmd)
   );

   // datapath: hold pending run, store literals, select the next code byte
   pbrle_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .pk_stat         (pk_stat),
      .req_data_byte   (req_data_byte),
      .req_end_of_data (req_end_of_data),
      .dp_stat         (dp_stat),
      .byte_valid      (byte_valid),
      .byte_data       (byte_data)
   );

   // packer: gather four code bytes a word, mark the final word of a request
   pbrle_pack u_pack (
      .clock            (clock),
      .reset            (reset),
      .byte_valid       (byte_valid),
      .byte_data        (byte_data),
      .finish           (cmd.finish),
      .pk_stat          (pk_stat),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_code_word    (rsp_code_word),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_last_of_item (rsp_last_of_item)
   );

endmodule

// ----- sv/pbrle_pack.sv -----
// Byte packer and result register: four code bytes to a word, earliest lowest.
// Depends on pbrle_pkg.
module pbrle_pack (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         byte_valid,
   input  logic [7:0]                   byte_data,
   input  logic                         finish,
   output pbrle_pkg::pk_stat_type       pk_stat,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [31:0]                  rsp_code_word,
   output logic [2:0]                   rsp_byte_count,
   output logic                         rsp_last_of_item
);

   logic [31:0]                    word_ff, word_in;
   logic [pbrle_pkg::BCNT_W-1:0]   cnt_ff, cnt_in;
   logic                           out_valid_ff, out_valid_in;
   logic [31:0]                    out_word_ff, out_word_in;
   logic [2:0]                     out_cnt_ff, out_cnt_in;
   logic                           out_last_ff, out_last_in;
   logic                           out_free;
   logic                           word_full;
   logic                           byte_take;
   logic                           fin_take;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign word_full = (cnt_ff == pbrle_pkg::BCNT_W'(pbrle_pkg::WORD_BYTES));
   assign byte_take = byte_valid && (!word_full || out_free);
   assign fin_take  = finish && ((cnt_ff == '0) || out_free);

   assign pk_stat.byte_rdy = !word_full || out_free;
   assign pk_stat.fin_rdy  = (cnt_ff == '0) || out_free;

   always_comb begin
      word_in      = word_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_word_in  = out_word_ff;
      out_cnt_in   = out_cnt_ff;
      out_last_in  = out_last_ff;
      if (byte_take) begin
         if (word_full) begin
            // full word leaves as a middle word, new byte opens the next
            out_valid_in = 1'b1;
            out_word_in  = word_ff;
            out_cnt_in   = 3'(cnt_ff);
            out_last_in  = 1'b0;
            word_in      = {24'd0, byte_data};
            cnt_in       = pbrle_pkg::BCNT_W'(1);
         end else begin
            if (cnt_ff == '0) begin
               word_in = '0;
            end
            word_in[8*cnt_ff[pbrle_pkg::POS_W-1:0] +: 8] = byte_data;
            cnt_in = cnt_ff + pbrle_pkg::BCNT_W'(1);
         end
      end
      if (fin_take && (cnt_ff != '0)) begin
         out_valid_in = 1'b1;
         out_word_in  = word_ff;
         out_cnt_in   = 3'(cnt_ff);
         out_last_in  = 1'b1;
         cnt_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
      word_ff     <= word_in;
      out_word_ff <= out_word_in;
      out_cnt_ff  <= out_cnt_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_code_word    = out_word_ff;
   assign rsp_byte_count   = out_cnt_ff;
   assign rsp_last_of_item = out_last_ff;

endmodule

// ----- sv/pbrle_dp.sv -----
// Encoder datapath: run and literal state, literal memory, code byte select.
// Depends on pbrle_pkg; commanded by pbrle_ctrl.
module pbrle_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  pbrle_pkg::cmd_type           cmd,
   input  pbrle_pkg::pk_stat_type       pk_stat,
   input  logic [7:0]                   req_data_byte,
   input  logic                         req_end_of_data,
   output pbrle_pkg::dp_stat_type       dp_stat,
   output logic                         byte_valid,
   output logic [7:0]                   byte_data
);

   logic [7:0]               b_ff, b_in;
   logic                     eod_ff, eod_in;
   logic [7:0]               prev_ff, prev_in;
   logic                     have_ff, have_in;
   pbrle_pkg::cnt_type       rc_ff, rc_in;
   pbrle_pkg::cnt_type       lit_count_ff, lit_count_in;
   pbrle_pkg::cnt_type       lit_idx_ff, lit_idx_in;
   logic [7:0]               lit_mem [pbrle_pkg::MAX_CHUNK];
   logic [7:0]               lit_rd_ff;
   logic                     rd_en;
   logic                     byte_take;
   logic                     lit_done;

   assign byte_valid = (cmd.byte_sel != pbrle_pkg::BSEL_NONE);
   assign byte_take  = byte_valid && pk_stat.byte_rdy;
   assign lit_done   = (lit_idx_ff == lit_count_ff);
   assign rd_en      = byte_take && ((cmd.byte_sel == pbrle_pkg::BSEL_LIT_HDR) ||
                       ((cmd.byte_sel == pbrle_pkg::BSEL_LIT_BYTE) && !lit_done));

   always_comb begin
      case (cmd.byte_sel)
         pbrle_pkg::BSEL_RUN_HDR:  byte_data = 8'(9'd257 - 9'(rc_ff));
         pbrle_pkg::BSEL_RUN_BYTE: byte_data = prev_ff;
         pbrle_pkg::BSEL_LIT_HDR:  byte_data = 8'(lit_count_ff - pbrle_pkg::CNT_W'(1));
         pbrle_pkg::BSEL_LIT_BYTE: byte_data = lit_rd_ff;
         default:                  byte_data = 8'd0;
      endcase
   end

   always_comb begin
      b_in         = b_ff;
      eod_in       = eod_ff;
      prev_in      = prev_ff;
      have_in      = have_ff;
      rc_in        = rc_ff;
      lit_count_in = lit_count_ff;
      lit_idx_in   = lit_idx_ff;
      if (cmd.load) begin
         b_in   = req_data_byte;
         eod_in = req_end_of_data;
      end
      if (cmd.set_new) begin
         prev_in = b_ff;
         rc_in   = pbrle_pkg::CNT_W'(1);
      end
      if (cmd.set_have) begin
         have_in = 1'b1;
      end
      if (cmd.rc_inc) begin
         rc_in = rc_ff + pbrle_pkg::CNT_W'(1);
      end
      if (cmd.clear_stream) begin
         rc_in   = '0;
         have_in = 1'b0;
      end
      if (cmd.push_prev) begin
         lit_count_in = lit_count_ff + pbrle_pkg::CNT_W'(1);
      end
      if (byte_take) begin
         case (cmd.byte_sel)
            pbrle_pkg::BSEL_RUN_BYTE: rc_in = '0;
            pbrle_pkg::BSEL_LIT_HDR:  lit_idx_in = pbrle_pkg::CNT_W'(1);
            pbrle_pkg::BSEL_LIT_BYTE: begin
               if (lit_done) begin
                  lit_count_in = '0;
                  lit_idx_in   = '0;
               end else begin
                  lit_idx_in = lit_idx_ff + pbrle_pkg::CNT_W'(1);
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         have_ff      <= 1'b0;
         rc_ff        <= '0;
         lit_count_ff <= '0;
         lit_idx_ff   <= '0;
      end else begin
         prev_ff      <= prev_in;
         have_ff      <= have_in;
         rc_ff        <= rc_in;
         lit_count_ff <= lit_count_in;
         lit_idx_ff   <= lit_idx_in;
      end
      b_ff   <= b_in;
      eod_ff <= eod_in;
   end

   // literal memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.push_prev) begin
         lit_mem[lit_count_ff[pbrle_pkg::ADDR_W-1:0]] <= prev_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         lit_rd_ff <= lit_mem[lit_idx_ff[pbrle_pkg::ADDR_W-1:0]];
      end
   end

   assign dp_stat.have         = have_ff;
   assign dp_stat.match        = (b_ff == prev_ff);
   assign dp_stat.eod          = eod_ff;
   assign dp_stat.rc_gt1       = (rc_ff > pbrle_pkg::CNT_W'(1));
   assign dp_stat.rc_eq1       = (rc_ff == pbrle_pkg::CNT_W'(1));
   assign dp_stat.rc_pre_max   = (rc_ff == pbrle_pkg::CNT_W'(pbrle_pkg::MAX_CHUNK - 1));
   assign dp_stat.rc_max       = (rc_ff == pbrle_pkg::CNT_W'(pbrle_pkg::MAX_CHUNK));
   assign dp_stat.lit_nz       = (lit_count_ff != '0);
   assign dp_stat.lit_pre_full = (lit_count_ff == pbrle_pkg::CNT_W'(pbrle_pkg::MAX_CHUNK - 1));
   assign dp_stat.lit_done     = lit_done;

endmodule

// ----- sv/pbrle_ctrl.sv -----
// Encoder sequencer: orders run codes, literal flushes and word packing.
// Depends on pbrle_pkg; drives pbrle_dp and pbrle_pack.
module pbrle_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  pbrle_pkg::dp_stat_type       dp_stat,
   input  pbrle_pkg::pk_stat_type       pk_stat,
   output pbrle_pkg::cmd_type           cmd
);

   pbrle_pkg::state_type state_ff, state_in;
   pbrle_pkg::state_type ret_ff, ret_in;
   pbrle_pkg::state_type cont;
   pbrle_pkg::state_type after;

   // cont: nothing emitted yet, may return straight to idle
   assign cont  = dp_stat.eod ? pbrle_pkg::ST_EOD_CHECK : pbrle_pkg::ST_IDLE;
   assign after = dp_stat.eod ? pbrle_pkg::ST_EOD_CHECK : pbrle_pkg::ST_FINISH;

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         pbrle_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = pbrle_pkg::ST_DECIDE;
            end
         end
         pbrle_pkg::ST_DECIDE: begin
            if (!dp_stat.have) begin
               cmd.set_new  = 1'b1;
               cmd.set_have = 1'b1;
               state_in     = cont;
            end else if (dp_stat.match) begin
               cmd.rc_inc = 1'b1;
               if (dp_stat.lit_nz) begin
                  ret_in   = pbrle_pkg::ST_POST_EQ;
                  state_in = pbrle_pkg::ST_LIT_HDR;
               end else if (dp_stat.rc_pre_max) begin
                  ret_in   = after;
                  state_in = pbrle_pkg::ST_RUN_HDR;
               end else begin
                  state_in = cont;
               end
            end else if (dp_stat.rc_gt1) begin
               ret_in   = pbrle_pkg::ST_SET_NEW;
               state_in = pbrle_pkg::ST_RUN_HDR;
            end else if (dp_stat.rc_eq1) begin
               // store the old byte as a literal and take the new one
               cmd.push_prev = 1'b1;
               cmd.set_new   = 1'b1;
               if (dp_stat.lit_pre_full) begin
                  ret_in   = after;
                  state_in = pbrle_pkg::ST_LIT_HDR;
               end else begin
                  state_in = cont;
               end
            end else begin
               cmd.set_new = 1'b1;
               state_in    = cont;
            end
         end
         pbrle_pkg::ST_POST_EQ: begin
            if (dp_stat.rc_max) begin
               ret_in   = after;
               state_in = pbrle_pkg::ST_RUN_HDR;
            end else begin
               state_in = after;
            end
         end
         pbrle_pkg::ST_SET_NEW: begin
            cmd.set_new = 1'b1;
            state_in    = after;
         end
         pbrle_pkg::ST_RUN_HDR: begin
            cmd.byte_sel = pbrle_pkg::BSEL_RUN_HDR;
            if (pk_stat.byte_rdy) begin
               state_in = pbrle_pkg::ST_RUN_BYTE;
            end
         end
         pbrle_pkg::ST_RUN_BYTE: begin
            cmd.byte_sel = pbrle_pkg::BSEL_RUN_BYTE;
            if (pk_stat.byte_rdy) begin
               state_in = ret_ff;
            end
         end
         pbrle_pkg::ST_LIT_HDR: begin
            cmd.byte_sel = pbrle_pkg::BSEL_LIT_HDR;
            if (pk_stat.byte_rdy) begin
               state_in = pbrle_pkg::ST_LIT_BYTE;
            end
         end
         pbrle_pkg::ST_LIT_BYTE: begin
            cmd.byte_sel = pbrle_pkg::BSEL_LIT_BYTE;
            if (pk_stat.byte_rdy && dp_stat.lit_done) begin
               state_in = ret_ff;
            end
         end
         pbrle_pkg::ST_EOD_CHECK: begin
            if (dp_stat.rc_gt1) begin
               ret_in   = pbrle_pkg::ST_FINAL_FLUSH;
               state_in = pbrle_pkg::ST_RUN_HDR;
            end else begin
               cmd.push_prev = dp_stat.rc_eq1;
               state_in      = pbrle_pkg::ST_FINAL_FLUSH;
            end
         end
         pbrle_pkg::ST_FINAL_FLUSH: begin
            cmd.clear_stream = 1'b1;
            if (dp_stat.lit_nz) begin
               ret_in   = pbrle_pkg::ST_FINISH;
               state_in = pbrle_pkg::ST_LIT_HDR;
            end else begin
               state_in = pbrle_pkg::ST_FINISH;
            end
         end
         pbrle_pkg::ST_FINISH: begin
            cmd.finish = 1'b1;
            if (pk_stat.fin_rdy) begin
               state_in = pbrle_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pbrle_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pbrle_pkg::ST_IDLE;
         ret_ff   <= pbrle_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

endmodule

// ----- sv/pbrle_checker.sv -----
// Port-level checks of the PackBits encoder, bound to its top level.
// Depends on packbits_rle_encoder_core_assert.svh.
`include "packbits_rle_encoder_core_assert.svh"

module pbrle_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [7:0]  req_data_byte,
   input logic        req_end_of_data,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_code_word,
   input logic [2:0]  rsp_byte_count,
   input logic        rsp_last_of_item
);

   // a stalled result holds
   `PBRLE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_code_word) && $stable(rsp_byte_count) && $stable(rsp_last_of_item))

   // a word carries one to four bytes
   `PBRLE_ASSERT_IMPL(a_cnt_range, clock, reset, rsp_valid, (rsp_byte_count != 3'd0) && (rsp_byte_count <= 3'd4))

   // only the final word of a request may be partly filled
   `PBRLE_ASSERT_IMPL(a_partial_last, clock, reset, rsp_valid && (rsp_byte_count != 3'd4), rsp_last_of_item)

   // bytes above the count are zero
   `PBRLE_ASSERT_IMPL(a_upper_zero, clock, reset, rsp_valid, ((rsp_byte_count != 3'd1) || (rsp_code_word[31:8] == 24'd0)) && ((rsp_byte_count != 3'd2) || (rsp_code_word[31:16] == 16'd0)) && ((rsp_byte_count != 3'd3) || (rsp_code_word[31:24] == 8'd0)))

   // a request is worked on before the next one is taken
   `PBRLE_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall)

endmodule

bind packbits_rle_encoder_core pbrle_checker u_chk (.*);
